// ===== rtl/core/tth_pkg.sv =====
// tth_pkg: shared types, widths and constants of the turn-to-heading controller
// used by tth_div and turn_to_heading_controller_top; depends on nothing else
`timescale 1ns / 1ps

package tth_pkg;

   // field widths
   localparam int ANGLE_W    = 24;
   localparam int TIME_W     = 32;
   localparam int PULSE_W    = 12;
   localparam int ERR_W      = 16;
   localparam int MAG_W      = 15;
   localparam int GAIN_W     = 6;
   localparam int OFFSET_W   = 9;
   localparam int TOL_W      = 15;
   localparam int MS_W       = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // shared divider geometry
   localparam int DVD_W  = 30;
   localparam int DVS_W  = 16;
   localparam int QUO_W  = 14;
   localparam int STEP_W = 4;

   // quotient bits per division: heading wrap quotient stays below 256,
   // the two scaling divisions stay below 16384
   localparam logic [STEP_W-1:0] WRAP_STEPS  = 4'd8;
   localparam logic [STEP_W-1:0] SCALE_STEPS = 4'd14;

   // fixed-point constants
   localparam logic [PULSE_W-1:0] NEUTRAL_US = 12'd1500;
   localparam logic [DVS_W-1:0]   FULL_TURN  = 16'd36000;
   localparam logic [DVS_W-1:0]   PCT_DIV    = 16'd100;
   localparam logic signed [ERR_W:0] HALF_TURN_S = 17'sd18000;
   localparam logic signed [ERR_W:0] FULL_TURN_S = 17'sd36000;

   // command codes
   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND      = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP      = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MIN = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MAX = 4'd7;

   // register reset values
   localparam logic [GAIN_W-1:0]   GAIN_RST      = 6'd6;
   localparam logic [OFFSET_W-1:0] OFFSET_RST    = 9'd60;
   localparam logic [TOL_W-1:0]    TOLERANCE_RST = 15'd50;
   localparam logic [TOL_W-1:0]    BAND_RST      = 15'd800;
   localparam logic [MS_W-1:0]     RAMP_RST      = 16'd1000;
   localparam logic [MS_W-1:0]     SETTLE_RST    = 16'd400;
   localparam logic [PULSE_W-1:0]  PULSE_MIN_RST = 12'd1200;
   localparam logic [PULSE_W-1:0]  PULSE_MAX_RST = 12'd1800;

   typedef struct packed {
      logic                      command;
      logic signed [ANGLE_W-1:0] angle_cdeg;
      logic [TIME_W-1:0]         time_ms;
   } req_type;

   typedef struct packed {
      logic [PULSE_W-1:0]      left_pulse;
      logic [PULSE_W-1:0]      right_pulse;
      logic                    done_res;
      logic signed [ERR_W-1:0] heading_error;
   } rsp_type;

   // divider control and status
   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   // sequencer states
   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_WRAP = 8'b0000_0010,
      S_MUL1 = 8'b0000_0100,
      S_DIV1 = 8'b0000_1000,
      S_MUL2 = 8'b0001_0000,
      S_DIV2 = 8'b0010_0000,
      S_FIN  = 8'b0100_0000,
      S_EMIT = 8'b1000_0000
   } state_type;

endpackage

// ===== rtl/core/tth_div.sv =====
// tth_div: shared restoring divider, one quotient bit per cycle
// depends on tth_pkg for widths and the control/status structs
`timescale 1ns / 1ps

module tth_div (
   input  logic                         clock,
   input  logic                         reset,
   input  tth_pkg::div_ctl_type         ctl,
   input  logic [tth_pkg::DVD_W-1:0]    dividend,
   input  logic [tth_pkg::DVS_W-1:0]    divisor,
   output tth_pkg::div_sts_type         sts,
   output logic [tth_pkg::QUO_W-1:0]    quotient,
   output logic [tth_pkg::DVS_W-1:0]    remainder
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [tth_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic [tth_pkg::DVS_W-1:0]     rem_ff, rem_in;
   logic [tth_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [tth_pkg::DVS_W-1:0]     dvs_ff, dvs_in;

   logic [tth_pkg::DVD_W-1:0]     hi_part;
   logic [tth_pkg::QUO_W-1:0]     lo_part;
   logic [tth_pkg::DVS_W:0]       trial;
   logic [tth_pkg::DVS_W:0]       diff;
   logic                          fits;

   // load: high part goes to the partial remainder, low bits wait in the quotient shifter
   assign hi_part = dividend >> ctl.steps;
   assign lo_part = dividend[tth_pkg::QUO_W-1:0]
                    << (tth_pkg::STEP_W'(tth_pkg::QUO_W) - ctl.steps);

   // one restoring step
   assign trial = {rem_ff, quo_ff[tth_pkg::QUO_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = ctl.steps;
         rem_in  = hi_part[tth_pkg::DVS_W-1:0];
         quo_in  = lo_part;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[tth_pkg::DVS_W-1:0] : trial[tth_pkg::DVS_W-1:0];
         quo_in = {quo_ff[tth_pkg::QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == tth_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   // a new division never lands on one in flight
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff)
      else $error("divider started while busy");

   // the caller must keep the high part below the divisor, so the result is exact
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < dvs_ff)
      else $error("divider remainder not below divisor");

   // step counter stays in range while running
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0) && (cnt_ff <= tth_pkg::STEP_W'(tth_pkg::QUO_W)))
      else $error("divider step count out of range");

   // done comes in the cycle right after the last step, with busy low
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finishing step");

endmodule

// ===== rtl/core/turn_to_heading_controller_top.sv =====
// turn_to_heading_controller_top: sequencer, state and output register of the
// turn-to-heading controller; depends on tth_pkg and instantiates tth_div
`timescale 1ns / 1ps

// Usage
//   req_* channel: one beat per command. command start stores the target heading
//   and arms the turn; command sample carries the gyro heading and millisecond clock.
//   rsp_* channel: exactly one beat per request beat, in order: equal left/right
//   pulses, a done flag and the signed shortest heading error.
//   csr_* channel: register writes (index, data), always ready; write only while
//   no request is in flight.
// Sequencing
//   One request at a time; req_stall is high while a beat is being worked on.
//   A sample while no turn is armed goes straight to the response; a start beat
//   first wraps the heading, and an armed sample wraps the heading and then runs
//   the gain scaling, plus the ramp scaling inside the ramp period. The shared
//   divider, giving one quotient bit per cycle (8 bits for the heading wrap, 14
//   for each scaling step), sets how long this takes.
// Reset
//   Synchronous, active high: registers return to their defaults, the turn is
//   disarmed and no response is pending.
// Receiver stall
//   The response sits in an output register; the next request is still taken and
//   worked on, and its response waits until the held beat has been taken.

module turn_to_heading_controller_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tth_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tth_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tth_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tth_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // configuration registers
   logic [tth_pkg::GAIN_W-1:0]    gain_ff, gain_in;
   logic [tth_pkg::OFFSET_W-1:0]  offset_ff, offset_in;
   logic [tth_pkg::TOL_W-1:0]     tol_ff, tol_in;
   logic [tth_pkg::TOL_W-1:0]     band_ff, band_in;
   logic [tth_pkg::MS_W-1:0]      ramp_ff, ramp_in;
   logic [tth_pkg::MS_W-1:0]      settle_ff, settle_in;
   logic [tth_pkg::PULSE_W-1:0]   pmin_ff, pmin_in;
   logic [tth_pkg::PULSE_W-1:0]   pmax_ff, pmax_in;

   // turn state
   logic                          active_ff, active_in;
   logic [tth_pkg::DVS_W-1:0]     target_ff, target_in;
   logic [tth_pkg::TIME_W-1:0]    start_ff, start_in;
   logic [tth_pkg::TIME_W-1:0]    exit_ff, exit_in;

   // sequencer and work registers
   tth_pkg::state_type            state_ff, state_in;
   tth_pkg::req_type              req_ff, req_in;
   logic signed [tth_pkg::ERR_W-1:0] err_ff, err_in;
   logic [tth_pkg::MAG_W-1:0]     mag_ff, mag_in;
   logic [tth_pkg::QUO_W-1:0]     corr_ff, corr_in;
   logic [tth_pkg::MS_W-1:0]      elapsed_ff, elapsed_in;
   tth_pkg::rsp_type              res_ff, res_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   tth_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   // divider hookup
   tth_pkg::div_ctl_type          div_ctl;
   tth_pkg::div_sts_type          div_sts;
   logic [tth_pkg::DVD_W-1:0]     div_dividend;
   logic [tth_pkg::DVS_W-1:0]     div_divisor;
   logic [tth_pkg::QUO_W-1:0]     div_quo;
   logic [tth_pkg::DVS_W-1:0]     div_rem;

   // shared multiplier
   logic [tth_pkg::MS_W-1:0]      mul_a, mul_b;
   logic [2*tth_pkg::MS_W-1:0]    mul_p;

   // combinational helpers
   logic                          req_take;
   logic                          idle_sample;
   logic [tth_pkg::ANGLE_W-1:0]   angle_abs;
   logic [tth_pkg::DVS_W-1:0]     wrapped;
   logic signed [tth_pkg::ERR_W:0] err_raw, err_wrap, err_abs;
   logic [tth_pkg::QUO_W-1:0]     prop;
   logic signed [tth_pkg::ERR_W-1:0] tol_s, tol_neg;
   logic                          use_offset;
   logic [tth_pkg::TIME_W-1:0]    elapsed_full;
   logic                          ramp_on;
   logic signed [tth_pkg::ERR_W-1:0] pulse_s, neutral_s, corr_s, pmin_s, pmax_s;
   logic [tth_pkg::PULSE_W-1:0]   pulse_clamped;
   logic                          exit_hit;
   logic [tth_pkg::TIME_W-1:0]    settle_diff;
   logic                          complete;
   logic                          out_free;

   tth_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .sts       (div_sts),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_take    = req_valid && !req_stall;
   assign idle_sample = (req_data.command == tth_pkg::CMD_SAMPLE) && !active_ff;
   assign angle_abs   = req_data.angle_cdeg[tth_pkg::ANGLE_W-1] ?
                        (~req_data.angle_cdeg + 1'b1) : req_data.angle_cdeg;

   // heading wrap into 0..35999 from the divider remainder
   assign wrapped = (req_ff.angle_cdeg[tth_pkg::ANGLE_W-1] && (div_rem != '0)) ?
                    (tth_pkg::FULL_TURN - div_rem) : div_rem;

   // shortest signed error, half turn kept as is
   assign err_raw = $signed({1'b0, target_ff}) - $signed({1'b0, wrapped});
   always_comb begin
      if (err_raw > tth_pkg::HALF_TURN_S) begin
         err_wrap = err_raw - tth_pkg::FULL_TURN_S;
      end else if (err_raw < -tth_pkg::HALF_TURN_S) begin
         err_wrap = err_raw + tth_pkg::FULL_TURN_S;
      end else begin
         err_wrap = err_raw;
      end
   end
   assign err_abs = err_wrap[tth_pkg::ERR_W] ? -err_wrap : err_wrap;

   // proportional term outside deadband, offset outside tolerance
   assign prop       = (mag_ff < band_ff) ? '0 : div_quo;
   assign tol_s      = $signed({1'b0, tol_ff});
   assign tol_neg    = -tol_s;
   assign use_offset = (err_ff >= tol_s) || (err_ff <= tol_neg);

   // ramp window
   assign elapsed_full = req_ff.time_ms - start_ff;
   assign ramp_on      = elapsed_full < {{(tth_pkg::TIME_W-tth_pkg::MS_W){1'b0}}, ramp_ff};

   // pulse and clamp
   assign neutral_s = $signed({{(tth_pkg::ERR_W-tth_pkg::PULSE_W){1'b0}}, tth_pkg::NEUTRAL_US});
   assign corr_s    = $signed({{(tth_pkg::ERR_W-tth_pkg::QUO_W){1'b0}}, corr_ff});
   assign pmin_s    = $signed({{(tth_pkg::ERR_W-tth_pkg::PULSE_W){1'b0}}, pmin_ff});
   assign pmax_s    = $signed({{(tth_pkg::ERR_W-tth_pkg::PULSE_W){1'b0}}, pmax_ff});
   assign pulse_s   = err_ff[tth_pkg::ERR_W-1] ? (neutral_s + corr_s) : (neutral_s - corr_s);
   always_comb begin
      if (pulse_s < pmin_s) begin
         pulse_clamped = pmin_ff;
      end else if (pulse_s > pmax_s) begin
         pulse_clamped = pmax_ff;
      end else begin
         pulse_clamped = pulse_s[tth_pkg::PULSE_W-1:0];
      end
   end

   // settle test against the updated exit time
   assign exit_hit    = mag_ff > tol_ff;
   assign settle_diff = req_ff.time_ms - exit_ff;
   assign complete    = !exit_hit &&
                        (settle_diff > {{(tth_pkg::TIME_W-tth_pkg::MS_W){1'b0}}, settle_ff});

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // shared multiplier operands
   always_comb begin
      if (state_ff == tth_pkg::S_MUL2) begin
         mul_a = {{(tth_pkg::MS_W-tth_pkg::QUO_W){1'b0}}, corr_ff};
         mul_b = elapsed_ff;
      end else begin
         mul_a = {{(tth_pkg::MS_W-tth_pkg::MAG_W){1'b0}}, mag_ff};
         mul_b = {{(tth_pkg::MS_W-tth_pkg::GAIN_W){1'b0}}, gain_ff};
      end
   end
   assign mul_p = mul_a * mul_b;

   // divider launch
   always_comb begin
      div_ctl.start = 1'b0;
      div_ctl.steps = tth_pkg::SCALE_STEPS;
      div_dividend  = mul_p[tth_pkg::DVD_W-1:0];
      div_divisor   = tth_pkg::PCT_DIV;
      case (state_ff)
         tth_pkg::S_IDLE: begin
            div_ctl.start = req_take && !idle_sample;
            div_ctl.steps = tth_pkg::WRAP_STEPS;
            div_dividend  = {{(tth_pkg::DVD_W-tth_pkg::ANGLE_W){1'b0}}, angle_abs};
            div_divisor   = tth_pkg::FULL_TURN;
         end
         tth_pkg::S_MUL1: begin
            div_ctl.start = 1'b1;
         end
         tth_pkg::S_MUL2: begin
            div_ctl.start = 1'b1;
            div_divisor   = ramp_ff;
         end
         default: begin
         end
      endcase
   end

   // configuration writes
   always_comb begin
      gain_in   = gain_ff;
      offset_in = offset_ff;
      tol_in    = tol_ff;
      band_in   = band_ff;
      ramp_in   = ramp_ff;
      settle_in = settle_ff;
      pmin_in   = pmin_ff;
      pmax_in   = pmax_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tth_pkg::CSR_GAIN:      gain_in   = csr_wdata[tth_pkg::GAIN_W-1:0];
            tth_pkg::CSR_OFFSET:    offset_in = csr_wdata[tth_pkg::OFFSET_W-1:0];
            tth_pkg::CSR_TOLERANCE: tol_in    = csr_wdata[tth_pkg::TOL_W-1:0];
            tth_pkg::CSR_BAND:      band_in   = csr_wdata[tth_pkg::TOL_W-1:0];
            tth_pkg::CSR_RAMP:      ramp_in   = csr_wdata[tth_pkg::MS_W-1:0];
            tth_pkg::CSR_SETTLE:    settle_in = csr_wdata[tth_pkg::MS_W-1:0];
            tth_pkg::CSR_PULSE_MIN: pmin_in   = csr_wdata[tth_pkg::PULSE_W-1:0];
            tth_pkg::CSR_PULSE_MAX: pmax_in   = csr_wdata[tth_pkg::PULSE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      err_in       = err_ff;
      mag_in       = mag_ff;
      corr_in      = corr_ff;
      elapsed_in   = elapsed_ff;
      res_in       = res_ff;
      active_in    = active_ff;
      target_in    = target_ff;
      start_in     = start_ff;
      exit_in      = exit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         tth_pkg::S_IDLE: begin
            if (req_take) begin
               req_in = req_data;
               if (idle_sample) begin
                  res_in.left_pulse    = tth_pkg::NEUTRAL_US;
                  res_in.right_pulse   = tth_pkg::NEUTRAL_US;
                  res_in.done_res      = 1'b1;
                  res_in.heading_error = '0;
                  state_in = tth_pkg::S_EMIT;
               end else begin
                  state_in = tth_pkg::S_WRAP;
               end
            end
         end
         tth_pkg::S_WRAP: begin
            if (div_sts.done) begin
               if (req_ff.command == tth_pkg::CMD_START) begin
                  target_in = wrapped;
                  start_in  = req_ff.time_ms;
                  exit_in   = '0;
                  active_in = 1'b1;
                  res_in.left_pulse    = tth_pkg::NEUTRAL_US;
                  res_in.right_pulse   = tth_pkg::NEUTRAL_US;
                  res_in.done_res      = 1'b0;
                  res_in.heading_error = '0;
                  state_in = tth_pkg::S_EMIT;
               end else begin
                  err_in   = err_wrap[tth_pkg::ERR_W-1:0];
                  mag_in   = err_abs[tth_pkg::MAG_W-1:0];
                  state_in = tth_pkg::S_MUL1;
               end
            end
         end
         tth_pkg::S_MUL1: begin
            state_in = tth_pkg::S_DIV1;
         end
         tth_pkg::S_DIV1: begin
            if (div_sts.done) begin
               corr_in    = prop + (use_offset ?
                            {{(tth_pkg::QUO_W-tth_pkg::OFFSET_W){1'b0}}, offset_ff} : '0);
               elapsed_in = elapsed_full[tth_pkg::MS_W-1:0];
               state_in   = ramp_on ? tth_pkg::S_MUL2 : tth_pkg::S_FIN;
            end
         end
         tth_pkg::S_MUL2: begin
            state_in = tth_pkg::S_DIV2;
         end
         tth_pkg::S_DIV2: begin
            if (div_sts.done) begin
               corr_in  = div_quo;
               state_in = tth_pkg::S_FIN;
            end
         end
         tth_pkg::S_FIN: begin
            if (exit_hit) begin
               exit_in = req_ff.time_ms;
            end
            res_in.heading_error = err_ff;
            if (complete) begin
               active_in          = 1'b0;
               target_in          = '0;
               res_in.left_pulse  = tth_pkg::NEUTRAL_US;
               res_in.right_pulse = tth_pkg::NEUTRAL_US;
               res_in.done_res    = 1'b1;
            end else begin
               res_in.left_pulse  = pulse_clamped;
               res_in.right_pulse = pulse_clamped;
               res_in.done_res    = 1'b0;
            end
            state_in = tth_pkg::S_EMIT;
         end
         tth_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = tth_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tth_pkg::S_IDLE;
         end
      endcase
   end

   // control and turn state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tth_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         target_ff    <= '0;
         start_ff     <= '0;
         exit_ff      <= '0;
         gain_ff      <= tth_pkg::GAIN_RST;
         offset_ff    <= tth_pkg::OFFSET_RST;
         tol_ff       <= tth_pkg::TOLERANCE_RST;
         band_ff      <= tth_pkg::BAND_RST;
         ramp_ff      <= tth_pkg::RAMP_RST;
         settle_ff    <= tth_pkg::SETTLE_RST;
         pmin_ff      <= tth_pkg::PULSE_MIN_RST;
         pmax_ff      <= tth_pkg::PULSE_MAX_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         target_ff    <= target_in;
         start_ff     <= start_in;
         exit_ff      <= exit_in;
         gain_ff      <= gain_in;
         offset_ff    <= offset_in;
         tol_ff       <= tol_in;
         band_ff      <= band_in;
         ramp_ff      <= ramp_in;
         settle_ff    <= settle_in;
         pmin_ff      <= pmin_in;
         pmax_ff      <= pmax_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      err_ff      <= err_in;
      mag_ff      <= mag_in;
      corr_ff     <= corr_in;
      elapsed_ff  <= elapsed_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != tth_pkg::S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // an accepted beat always starts work
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != tth_pkg::S_IDLE)
      else $error("accepted beat did not start work");

   // a disarmed controller holds no target
   a_idle_target: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> target_ff == '0)
      else $error("target kept while disarmed");

   // a done response is always neutral
   a_done_neutral: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res |->
         rsp_data_ff.left_pulse == tth_pkg::NEUTRAL_US)
      else $error("done response with non-neutral pulse");

   // both sides always get the same pulse
   a_sides_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.left_pulse == rsp_data_ff.right_pulse)
      else $error("left and right pulses differ");

   // the divider is only waited on while it runs or has just finished
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tth_pkg::S_DIV1 || state_ff == tth_pkg::S_DIV2) |->
         div_sts.busy || div_sts.done)
      else $error("waiting on an idle divider");

endmodule

// ===== verif/tb.sv =====
// tb: self-checking bench for turn_to_heading_controller_top, with a clocked
// driver, stall generator and checker around a bit-accurate heading predictor
// depends on tth_pkg and the controller rtl only
`timescale 1ns / 1ps

module tb;

   localparam int TURN_CDEG   = 36000;
   localparam int HALF_CDEG   = 18000;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_BEATS = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tth_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   tth_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [tth_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tth_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copy of the registers and turn state
   logic [tth_pkg::GAIN_W-1:0]   cfg_gain   = tth_pkg::GAIN_RST;
   logic [tth_pkg::OFFSET_W-1:0] cfg_offset = tth_pkg::OFFSET_RST;
   logic [tth_pkg::TOL_W-1:0]    cfg_tol    = tth_pkg::TOLERANCE_RST;
   logic [tth_pkg::TOL_W-1:0]    cfg_band   = tth_pkg::BAND_RST;
   logic [tth_pkg::MS_W-1:0]     cfg_ramp   = tth_pkg::RAMP_RST;
   logic [tth_pkg::MS_W-1:0]     cfg_settle = tth_pkg::SETTLE_RST;
   logic [tth_pkg::PULSE_W-1:0]  cfg_pmin   = tth_pkg::PULSE_MIN_RST;
   logic [tth_pkg::PULSE_W-1:0]  cfg_pmax   = tth_pkg::PULSE_MAX_RST;
   bit                           armed      = 1'b0;
   int                           aim_cdeg   = 0;
   logic [tth_pkg::TIME_W-1:0]   t_start    = '0;
   logic [tth_pkg::TIME_W-1:0]   t_exit     = '0;

   tth_pkg::req_type cmd_queue[$];
   tth_pkg::rsp_type drive_queue[$];

   logic req_fire = 1'b0;
   bit   idle_on  = 1'b1;
   int   gap_left = 0;
   int   stall_left = 0;
   int   cycle_count = 0;
   int   fail_count = 0;
   int   n_start = 0;
   int   n_sample = 0;
   int   n_turns_done = 0;
   int   n_checked = 0;
   int   n_csr = 0;

   turn_to_heading_controller_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // heading folded into 0 .. 35999
   function automatic int wrap_cdeg(logic signed [tth_pkg::ANGLE_W-1:0] angle);
      int r;
      r = int'(angle) % TURN_CDEG;
      if (r < 0) r += TURN_CDEG;
      return r;
   endfunction

   // drive result of one command beat, updating the turn state
   function automatic tth_pkg::rsp_type steer_step(tth_pkg::req_type cmd);
      tth_pkg::rsp_type res;
      longint err, mag, corr, pulse, tol;
      logic [tth_pkg::TIME_W-1:0] now, elapsed, since;
      now = cmd.time_ms;
      tol = longint'(cfg_tol);
      res.left_pulse    = tth_pkg::NEUTRAL_US;
      res.right_pulse   = tth_pkg::NEUTRAL_US;
      res.done_res      = 1'b1;
      res.heading_error = '0;
      if (cmd.command == tth_pkg::CMD_START) begin
         aim_cdeg = wrap_cdeg(cmd.angle_cdeg);
         t_start  = now;
         t_exit   = '0;
         armed    = 1'b1;
         res.done_res = 1'b0;
         return res;
      end
      if (!armed) return res;

      // shortest signed error, half turn kept as is
      err = longint'(aim_cdeg) - longint'(wrap_cdeg(cmd.angle_cdeg));
      if (err > HALF_CDEG) err -= TURN_CDEG;
      else if (err < -HALF_CDEG) err += TURN_CDEG;
      mag = (err < 0) ? -err : err;

      // proportional term outside the band, offset outside tolerance
      if (mag < longint'(cfg_band)) corr = 0;
      else corr = (err * longint'(cfg_gain)) / 100;
      if (err >= tol) corr += longint'(cfg_offset);
      else if (err <= -tol) corr -= longint'(cfg_offset);

      // ramp in after start
      elapsed = now - t_start;
      if (elapsed < {16'd0, cfg_ramp})
         corr = (corr * longint'(elapsed)) / longint'(cfg_ramp);

      // clamp, low bound checked first
      pulse = longint'(tth_pkg::NEUTRAL_US) - corr;
      if (pulse < longint'(cfg_pmin)) pulse = longint'(cfg_pmin);
      else if (pulse > longint'(cfg_pmax)) pulse = longint'(cfg_pmax);

      if (mag > tol) t_exit = now;
      res.heading_error = err[tth_pkg::ERR_W-1:0];
      since = now - t_exit;
      if (since > {16'd0, cfg_settle}) begin
         armed    = 1'b0;
         aim_cdeg = 0;
         n_turns_done++;
         return res;
      end
      res.left_pulse  = pulse[tth_pkg::PULSE_W-1:0];
      res.right_pulse = pulse[tth_pkg::PULSE_W-1:0];
      res.done_res    = 1'b0;
      return res;
   endfunction

   task automatic check_field(string what, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         fail_count++;
      end
   endtask

   // checker, predictor update and cycle guard on the rising edge
   always @(posedge clock) begin
      tth_pkg::rsp_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d drive results still owed", $time, drive_queue.size());
         $display("FAIL turn_to_heading_controller_top");
         $finish;
      end
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         // register writes
         if (csr_valid && csr_ready) begin
            n_csr++;
            case (csr_index)
               tth_pkg::CSR_GAIN:      cfg_gain   = csr_wdata[tth_pkg::GAIN_W-1:0];
               tth_pkg::CSR_OFFSET:    cfg_offset = csr_wdata[tth_pkg::OFFSET_W-1:0];
               tth_pkg::CSR_TOLERANCE: cfg_tol    = csr_wdata[tth_pkg::TOL_W-1:0];
               tth_pkg::CSR_BAND:      cfg_band   = csr_wdata[tth_pkg::TOL_W-1:0];
               tth_pkg::CSR_RAMP:      cfg_ramp   = csr_wdata[tth_pkg::MS_W-1:0];
               tth_pkg::CSR_SETTLE:    cfg_settle = csr_wdata[tth_pkg::MS_W-1:0];
               tth_pkg::CSR_PULSE_MIN: cfg_pmin   = csr_wdata[tth_pkg::PULSE_W-1:0];
               tth_pkg::CSR_PULSE_MAX: cfg_pmax   = csr_wdata[tth_pkg::PULSE_W-1:0];
               default: ;
            endcase
         end
         // result beat against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (drive_queue.size() == 0) begin
               $display("%0t: unexpected result beat, pulse %0d done %0b error %0d",
                        $time, rsp_data.left_pulse, rsp_data.done_res,
                        rsp_data.heading_error);
               fail_count++;
            end else begin
               want = drive_queue.pop_front();
               n_checked++;
               check_field("left_pulse", want.left_pulse, rsp_data.left_pulse);
               check_field("right_pulse", want.right_pulse, rsp_data.right_pulse);
               check_field("done_res", want.done_res, rsp_data.done_res);
               check_field("heading_error", want.heading_error, rsp_data.heading_error);
            end
         end
         // accepted command beat
         if (req_valid && !req_stall) begin
            if (req_data.command == tth_pkg::CMD_START) n_start++;
            else n_sample++;
            drive_queue.push_back(steer_step(req_data));
         end
      end
   end

   // command driver, holds a beat until taken, idles in bursts
   always @(negedge clock) begin
      if (req_valid && !req_fire) begin
         // beat still waiting
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (idle_on && cmd_queue.size() != 0 && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         gap_left = $urandom_range(0, 14);
      end else if (cmd_queue.size() != 0) begin
         req_valid <= 1'b1;
         req_data  <= cmd_queue.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result stall in bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 14);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic push_cmd(logic command, int angle, logic [tth_pkg::TIME_W-1:0] t);
      tth_pkg::req_type item;
      item.command    = command;
      item.angle_cdeg = tth_pkg::ANGLE_W'(angle);
      item.time_ms    = t;
      cmd_queue.push_back(item);
   endtask

   // start plus a run of samples closing in on the target
   task automatic queue_turn(output int pushed);
      int target, tw, e, k, steps, i;
      logic [tth_pkg::TIME_W-1:0] t;
      target = int'($urandom_range(0, 16777215)) - 8388608;
      tw = wrap_cdeg(tth_pkg::ANGLE_W'(target));
      case ($urandom_range(0, 2))
         0: t = $urandom_range(0, 500);
         1: t = $urandom;
         default: t = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      endcase
      push_cmd(tth_pkg::CMD_START, target, t);
      e = int'($urandom_range(0, 2 * HALF_CDEG)) - HALF_CDEG;
      steps = $urandom_range(3, 16);
      for (i = 0; i < steps; i++) begin
         t = t + $urandom_range(0, 300);
         k = int'($urandom_range(0, 460)) - 230;
         push_cmd(tth_pkg::CMD_SAMPLE, tw - e + k * TURN_CDEG, t);
         // shrink, sometimes overshoot, sometimes jitter near zero
         if ($urandom_range(0, 3) == 0)
            e = int'($urandom_range(0, 100)) - 50;
         else
            e = e * int'($urandom_range(0, 90)) / 100 * (($urandom_range(0, 5) == 0) ? -1 : 1);
      end
      pushed = steps + 1;
   endtask

   task automatic write_reg(logic [tth_pkg::CSR_IDX_W-1:0] idx, int val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= tth_pkg::CSR_DATA_W'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_settings(int g, int o, int tl, int b, int rp, int st, int mn, int mx);
      write_reg(tth_pkg::CSR_GAIN, g);
      write_reg(tth_pkg::CSR_OFFSET, o);
      write_reg(tth_pkg::CSR_TOLERANCE, tl);
      write_reg(tth_pkg::CSR_BAND, b);
      write_reg(tth_pkg::CSR_RAMP, rp);
      write_reg(tth_pkg::CSR_SETTLE, st);
      write_reg(tth_pkg::CSR_PULSE_MIN, mn);
      write_reg(tth_pkg::CSR_PULSE_MAX, mx);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // all commands taken and all results back, checked on the rising edge
   // where the driver outputs have settled
   task automatic wait_idle;
      while (cmd_queue.size() != 0 || req_valid || drive_queue.size() != 0)
         @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   // stimulus sequence
   initial begin
      int ph, count, n;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: idle samples, wraps, half turn, clamps, completion
      load_settings(tth_pkg::GAIN_RST, tth_pkg::OFFSET_RST, tth_pkg::TOLERANCE_RST,
                    tth_pkg::BAND_RST, tth_pkg::RAMP_RST, tth_pkg::SETTLE_RST,
                    tth_pkg::PULSE_MIN_RST, tth_pkg::PULSE_MAX_RST);
      push_cmd(tth_pkg::CMD_SAMPLE, -8388608, 32'h0000_0000);
      push_cmd(tth_pkg::CMD_SAMPLE, 8388607, 32'hFFFF_FFFF);
      push_cmd(tth_pkg::CMD_START, -8388608, 32'hFFFF_FF00);
      push_cmd(tth_pkg::CMD_SAMPLE, 17392, 32'hFFFF_FF10);
      push_cmd(tth_pkg::CMD_SAMPLE, 30392, 32'h0000_0100);
      push_cmd(tth_pkg::CMD_SAMPLE, -608, 32'h0000_0400);
      push_cmd(tth_pkg::CMD_START, 0, 32'd100);
      push_cmd(tth_pkg::CMD_SAMPLE, 0, 32'd200);
      push_cmd(tth_pkg::CMD_SAMPLE, 20, 32'd600);
      push_cmd(tth_pkg::CMD_START, HALF_CDEG, 32'd0);
      push_cmd(tth_pkg::CMD_SAMPLE, 0, 32'd5000);
      push_cmd(tth_pkg::CMD_SAMPLE, 30000, 32'd5001);
      push_cmd(tth_pkg::CMD_SAMPLE, HALF_CDEG + 200 * TURN_CDEG, 32'd5002);
      push_cmd(tth_pkg::CMD_START, 0, 32'd0);
      push_cmd(tth_pkg::CMD_SAMPLE, HALF_CDEG, 32'd3000);
      wait_idle();

      // top extremes, zero tolerance and band, no ramp, crossed clamp
      load_settings(63, 500, 0, 0, 0, 65535, 2500, 500);
      push_cmd(tth_pkg::CMD_START, 1000, 32'd50);
      push_cmd(tth_pkg::CMD_SAMPLE, 1000, 32'd60);
      push_cmd(tth_pkg::CMD_SAMPLE, 900, 32'd70);
      push_cmd(tth_pkg::CMD_SAMPLE, 19000, 32'd80);
      wait_idle();

      // bottom extremes, widest tolerance, longest ramp, instant settle
      load_settings(0, 0, 18000, 18000, 65535, 0, 500, 2500);
      push_cmd(tth_pkg::CMD_START, 5, 32'd0);
      push_cmd(tth_pkg::CMD_SAMPLE, 8388607, 32'd1);
      push_cmd(tth_pkg::CMD_SAMPLE, -8388608, 32'd2);
      wait_idle();

      // random phases, last one at defaults with no idling
      for (ph = 0; ph < 5; ph++) begin
         idle_on = (ph < 4);
         if (ph == 4)
            load_settings(tth_pkg::GAIN_RST, tth_pkg::OFFSET_RST, tth_pkg::TOLERANCE_RST,
                          tth_pkg::BAND_RST, tth_pkg::RAMP_RST, tth_pkg::SETTLE_RST,
                          tth_pkg::PULSE_MIN_RST, tth_pkg::PULSE_MAX_RST);
         else if ($urandom_range(0, 3) == 0)
            load_settings($urandom_range(0, 63), $urandom_range(0, 500),
                          $urandom_range(0, 18000), $urandom_range(0, 18000),
                          $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(500, 2500), $urandom_range(500, 2500));
         else
            load_settings($urandom_range(0, 63), $urandom_range(0, 500),
                          $urandom_range(0, 400), $urandom_range(0, 3000),
                          $urandom_range(0, 2000), $urandom_range(0, 1000),
                          $urandom_range(500, 1500), $urandom_range(1500, 2500));
         count = 0;
         while (count < PHASE_BEATS) begin
            if ($urandom_range(0, 4) == 0) begin
               push_cmd(($urandom_range(0, 3) == 0) ? tth_pkg::CMD_START : tth_pkg::CMD_SAMPLE,
                        int'($urandom_range(0, 16777215)) - 8388608, $urandom);
               count++;
            end else begin
               queue_turn(n);
               count += n;
            end
         end
         wait_idle();
      end

      repeat (60) @(negedge clock);
      $display("run covered %0d starts and %0d samples, %0d turns settled to completion",
               n_start, n_sample, n_turns_done);
      $display("%0d result beats checked, %0d register writes, %0d mismatches",
               n_checked, n_csr, fail_count);
      if (fail_count == 0 && drive_queue.size() == 0)
         $display("PASS turn_to_heading_controller_top");
      else
         $display("FAIL turn_to_heading_controller_top");
      $finish;
   end

endmodule
